// ===== hdl/tmcw_pkg.sv =====
// Shared types and constants for the text-mode console writer.
// No dependencies; imported by tmcw_sweep, the top level and the testbench.
`default_nettype none

package tmcw_pkg;

  // Field widths of the request and result words
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CIDX_W   = 11;
  localparam int unsigned LIDX_W   = 12;
  localparam int unsigned WORD_W   = 16;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_PUT     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RD_CELL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RD_LOG  = 2'd2;

  // Character codes with special handling
  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  // Screen word of an empty position, light gray on black
  localparam logic [WORD_W-1:0] BLANK_WORD = 16'h0700;

  // Cursor position after reset (start of the second row on a wide screen)
  localparam int unsigned CURSOR_RESET = 80;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   character;
    logic [CIDX_W-1:0]   cell_index;
    logic [LIDX_W-1:0]   log_index;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] serial_byte;
    logic              serial_valid;
    logic [WORD_W-1:0] read_data;
    logic [CIDX_W-1:0] cursor_position;
    logic [LIDX_W-1:0] log_position;
    logic              last;
  } out_rsp_t;

  // Per-cycle controls from the sweep unit to the memory ports
  typedef struct packed {
    logic scr_we;     // write screen store at the sweep write address
    logic scr_re;     // read screen store at the sweep read address
    logic scr_blank;  // write a blank word instead of the copied word
    logic log_we;     // write zero to the log store
    logic done;       // final step of the sweep
  } swp_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/tmcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/tmcw_sweep.sv =====
// Address sweep unit: clears both stores after reset and moves the screen
// up one row on a scroll. Depends on tmcw_pkg.
`default_nettype none

module tmcw_sweep #(
  parameter int unsigned LOG_DEPTH = 4096,
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output tmcw_pkg::swp_ctl_t                       ctl,
  output logic [$clog2(COLUMNS*ROWS)-1:0]          scr_waddr,
  output logic [$clog2(COLUMNS*ROWS)-1:0]          scr_raddr,
  output logic [$clog2(LOG_DEPTH)-1:0]             log_waddr
);

  import tmcw_pkg::*;

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
  localparam int unsigned LOG_AW     = $clog2(LOG_DEPTH);
  localparam int unsigned CLR_LEN    = (CELL_COUNT > LOG_DEPTH) ? CELL_COUNT : LOG_DEPTH;
  localparam int unsigned SW         = $clog2(CLR_LEN + 1);

  logic          active_r;
  logic          clear_r;
  logic [SW-1:0] cnt_r;
  logic [SW-1:0] wsub;
  logic [SW-1:0] waddr_full;
  logic [SW:0]   rd_sum;

  // Step decode: clear writes step k, scroll writes k-1 and reads k+COLUMNS
  always_comb begin
    ctl        = '0;
    wsub       = cnt_r - SW'(1);
    rd_sum     = (SW+1)'(cnt_r) + (SW+1)'(COLUMNS);
    waddr_full = cnt_r;
    if (active_r) begin
      if (clear_r) begin
        ctl.scr_we    = cnt_r < SW'(CELL_COUNT);
        ctl.log_we    = cnt_r < SW'(LOG_DEPTH);
        ctl.scr_blank = 1'b1;
        ctl.done      = cnt_r == SW'(CLR_LEN - 1);
      end else begin
        waddr_full    = wsub;
        ctl.scr_re    = rd_sum < (SW+1)'(CELL_COUNT);
        ctl.scr_we    = cnt_r != '0;
        ctl.scr_blank = wsub >= SW'(CELL_COUNT - COLUMNS);
        ctl.done      = cnt_r == SW'(CELL_COUNT);
      end
    end
  end

  assign scr_waddr = waddr_full[CELL_AW-1:0];
  assign scr_raddr = rd_sum[CELL_AW-1:0];
  assign log_waddr = cnt_r[LOG_AW-1:0];

  // Step counter; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      clear_r  <= 1'b1;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      clear_r  <= 1'b0;
      cnt_r    <= '0;
    end else if (active_r) begin
      cnt_r <= cnt_r + SW'(1);
      if (ctl.done) begin
        active_r <= 1'b0;
      end
    end
  end

  // Scroll must never overlap a running sweep
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !active_r)
    else $error("sweep started while busy");

  // A scroll copy reads ahead of the position it overwrites
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scr_re && ctl.scr_we) |-> (scr_raddr != scr_waddr))
    else $error("sweep read and write collide");

  // The done step ends the sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.done && !start) |=> !active_r)
    else $error("sweep kept running after done");

endmodule

`default_nettype wire

// ===== hdl/text_mode_console_writer.sv =====
// Top level of the text-mode console writer: sequencer, cursor and log
// pointer, output register. Depends on tmcw_pkg, tmcw_ram and tmcw_sweep.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid / in_stall  | tmcw_pkg::in_req_t
//   out_    | output    | out_valid / out_stall| tmcw_pkg::out_rsp_t
//
// After reset a clearing pass blanks the screen and zeroes the log; in_stall
// stays high meanwhile. A request passes through EXEC and EMIT1 after its
// accept (and EMIT2 for a newline, which gives two results); its first result
// is registered in EMIT1. A put that takes the cursor past the last cell adds
// a row copy in SCROLL through the single screen RAM port pair.
// One request is in work at a time; the result register may hold while the
// next request is taken, and a stalled output holds the sequencer in place.
`default_nettype none

module text_mode_console_writer #(
  parameter int unsigned LOG_DEPTH = 4096,
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tmcw_pkg::in_req_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tmcw_pkg::out_rsp_t       out_data
);

  import tmcw_pkg::*;

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
  localparam int unsigned LOG_AW     = $clog2(LOG_DEPTH);
  localparam int unsigned CUR_MAX    = (CELL_COUNT > CURSOR_RESET) ? CELL_COUNT : CURSOR_RESET;
  localparam int unsigned CUR_W      = $clog2(CUR_MAX + 1);
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned RST_COL    = CURSOR_RESET % COLUMNS;
  localparam int unsigned RST_ROW    = CURSOR_RESET - RST_COL;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  state_t              state_r;
  in_req_t             req_r;
  logic                hit_r;
  logic [CUR_W-1:0]    cursor_r;
  logic [CUR_W-1:0]    rowst_r;
  logic [COL_W-1:0]    col_r;
  logic [LOG_AW-1:0]   logwr_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_rsp_t            out_r;

  // Sweep unit and memories
  swp_ctl_t            swp_ctl;
  logic                swp_start;
  logic [CELL_AW-1:0]  swp_scr_waddr;
  logic [CELL_AW-1:0]  swp_scr_raddr;
  logic [LOG_AW-1:0]   swp_log_waddr;

  logic                scr_we;
  logic [CELL_AW-1:0]  scr_waddr;
  logic [WORD_W-1:0]   scr_wdata;
  logic                scr_re;
  logic [CELL_AW-1:0]  scr_raddr;
  logic [WORD_W-1:0]   scr_rdata;

  logic                log_we;
  logic [LOG_AW-1:0]   log_waddr;
  logic [CHAR_W-1:0]   log_wdata;
  logic                log_re;
  logic [LOG_AW-1:0]   log_rdata_addr;
  logic [CHAR_W-1:0]   log_rdata;

  // Request decode
  logic                is_put;
  logic                put_go;
  logic                is_lf;
  logic                cell_hit;
  logic                log_hit;

  // Cursor and log pointer update for a put
  logic                cur_wrap;
  logic [CUR_W-1:0]    cur_eff;
  logic [CUR_W-1:0]    row_eff;
  logic [COL_W-1:0]    col_eff;
  logic [COL_W:0]      col_inc;
  logic [CUR_W-1:0]    row_adv;
  logic [CUR_W-1:0]    cur_put;
  logic [CUR_W-1:0]    row_put;
  logic [COL_W-1:0]    col_put;
  logic                scroll_need;
  logic [LOG_AW:0]     log_inc;
  logic [LOG_AW-1:0]   log_nxt;

  logic                out_free;
  logic [WORD_W-1:0]   rd_word;

  tmcw_sweep #(
    .LOG_DEPTH (LOG_DEPTH),
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (swp_start),
    .ctl       (swp_ctl),
    .scr_waddr (swp_scr_waddr),
    .scr_raddr (swp_scr_raddr),
    .log_waddr (swp_log_waddr)
  );

  tmcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  tmcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .re    (log_re),
    .raddr (log_rdata_addr),
    .rdata (log_rdata)
  );

  // Request decode
  assign is_put   = req_r.action == ACT_PUT;
  assign put_go   = is_put && (req_r.character != CH_NUL);
  assign is_lf    = req_r.character == CH_LF;
  assign cell_hit = 32'(req_r.cell_index) < 32'(CELL_COUNT);
  assign log_hit  = 32'(req_r.log_index) < 32'(LOG_DEPTH);

  // Cursor step: wrap an off-screen cursor to the origin, then advance
  always_comb begin
    cur_wrap = cursor_r >= CUR_W'(CELL_COUNT);
    cur_eff  = cur_wrap ? '0 : cursor_r;
    row_eff  = cur_wrap ? '0 : rowst_r;
    col_eff  = cur_wrap ? '0 : col_r;
    col_inc  = (COL_W+1)'(col_eff) + (COL_W+1)'(1);
    row_adv  = row_eff + CUR_W'(COLUMNS);
    if (is_lf) begin
      cur_put = row_adv;
      row_put = row_adv;
      col_put = '0;
    end else begin
      cur_put = cur_eff + CUR_W'(1);
      if (col_inc == (COL_W+1)'(COLUMNS)) begin
        row_put = row_adv;
        col_put = '0;
      end else begin
        row_put = row_eff;
        col_put = col_inc[COL_W-1:0];
      end
    end
    scroll_need = cur_put == CUR_W'(CELL_COUNT);
  end

  // Log pointer advance with wrap at the ring depth
  always_comb begin
    log_inc = (LOG_AW+1)'(logwr_r) + (LOG_AW+1)'(1);
    log_nxt = (log_inc == (LOG_AW+1)'(LOG_DEPTH)) ? '0 : log_inc[LOG_AW-1:0];
  end

  assign swp_start = (state_r == ST_EXEC) && put_go && scroll_need;

  // Screen RAM port selection
  always_comb begin
    scr_we    = swp_ctl.scr_we;
    scr_waddr = swp_scr_waddr;
    scr_wdata = swp_ctl.scr_blank ? BLANK_WORD : scr_rdata;
    scr_re    = swp_ctl.scr_re;
    scr_raddr = swp_scr_raddr;
    if (state_r == ST_EXEC) begin
      scr_we    = put_go && !is_lf;
      scr_waddr = cur_eff[CELL_AW-1:0];
      scr_wdata = BLANK_WORD | WORD_W'(req_r.character);
      scr_re    = (req_r.action == ACT_RD_CELL) && cell_hit;
      scr_raddr = CELL_AW'(req_r.cell_index);
    end
  end

  // Log RAM port selection
  always_comb begin
    log_we         = swp_ctl.log_we;
    log_waddr      = swp_log_waddr;
    log_wdata      = '0;
    log_re         = 1'b0;
    log_rdata_addr = LOG_AW'(req_r.log_index);
    if (state_r == ST_EXEC) begin
      log_we    = put_go;
      log_waddr = logwr_r;
      log_wdata = req_r.character;
      log_re    = (req_r.action == ACT_RD_LOG) && log_hit;
    end
  end

  // Read data for the first result
  always_comb begin
    case (req_r.action)
      ACT_RD_CELL: rd_word = hit_r ? scr_rdata : '0;
      ACT_RD_LOG:  rd_word = hit_r ? WORD_W'(log_rdata) : '0;
      default:     rd_word = '0;
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Result register loads in an emit state, drains when taken
  assign out_valid_nxt = ((state_r == ST_EMIT1 || state_r == ST_EMIT2) && out_free) ||
                         (out_valid_r && out_stall);

  // Sequencer, cursor, log pointer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= CUR_W'(CURSOR_RESET);
      rowst_r     <= CUR_W'(RST_ROW);
      col_r       <= COL_W'(RST_COL);
      logwr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_CLEAR: begin
          if (swp_ctl.done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          hit_r <= (req_r.action == ACT_RD_CELL) ? cell_hit : log_hit;
          if (put_go) begin
            logwr_r  <= log_nxt;
            cursor_r <= cur_put;
            rowst_r  <= row_put;
            col_r    <= col_put;
          end
          state_r <= swp_start ? ST_SCROLL : ST_EMIT1;
        end
        ST_SCROLL: begin
          if (swp_ctl.done) begin
            cursor_r <= cursor_r - CUR_W'(COLUMNS);
            rowst_r  <= rowst_r - CUR_W'(COLUMNS);
            state_r  <= ST_EMIT1;
          end
        end
        ST_EMIT1: begin
          if (out_free) begin
            out_r.serial_byte     <= put_go ? req_r.character : '0;
            out_r.serial_valid    <= put_go;
            out_r.read_data       <= rd_word;
            out_r.cursor_position <= CIDX_W'(cursor_r);
            out_r.log_position    <= LIDX_W'(logwr_r);
            out_r.last            <= !(put_go && is_lf);
            state_r               <= (put_go && is_lf) ? ST_EMIT2 : ST_IDLE;
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            out_r.serial_byte     <= CH_CR;
            out_r.serial_valid    <= 1'b1;
            out_r.read_data       <= '0;
            out_r.cursor_position <= CIDX_W'(cursor_r);
            out_r.log_position    <= LIDX_W'(logwr_r);
            out_r.last            <= 1'b1;
            state_r               <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Cursor stays the sum of its row start and column between requests
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cursor_r == rowst_r + CUR_W'(col_r)))
    else $error("cursor out of step with row and column");

  // A finished scroll leaves the cursor at the start of the bottom row
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && swp_ctl.done) |=> (cursor_r == CUR_W'(CELL_COUNT - COLUMNS)))
    else $error("scroll left the cursor off the bottom row");

  // Log pointer stays inside the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(logwr_r) < 32'(LOG_DEPTH))
    else $error("log pointer beyond ring depth");

  // Sweep writes happen only during the clearing pass or a scroll
  assert property (@(posedge clk) disable iff (!rst_n)
    (swp_ctl.scr_we || swp_ctl.log_we) |-> (state_r == ST_CLEAR || state_r == ST_SCROLL))
    else $error("sweep write outside clear or scroll");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for text_mode_console_writer: screen, cursor, log ring
// and serial echo are predicted per request. Depends on tmcw_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcw_pkg::*;

  localparam int unsigned COLS           = 80;
  localparam int unsigned ROWS_N         = 25;
  localparam int unsigned CELLS          = COLS * ROWS_N;
  localparam int unsigned LOG_LEN        = 4096;
  // Longest quiet stretch: clearing pass or scroll copy plus stalls
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned REPORT_MAX     = 10;
  // Text phase and mixed phase together come to about 1700 requests
  localparam int unsigned TEXT_PUTS      = 600;
  localparam int unsigned RANDOM_REQS    = 1000;

  // Action code the block treats as a no-op
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_stall = 1'b0;
  in_req_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  out_rsp_t out_data;

  text_mode_console_writer #(
    .LOG_DEPTH(LOG_LEN),
    .COLUMNS  (COLS),
    .ROWS     (ROWS_N)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Console state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] scr_mem [0:CELLS-1];
  logic [CHAR_W-1:0] log_mem [0:LOG_LEN-1];
  int unsigned       cur_pos;
  int unsigned       log_wr;
  out_rsp_t          console_rsp_due[$];

  function automatic void clear_console();
    for (int i = 0; i < CELLS; i++) scr_mem[i] = BLANK_WORD;
    for (int i = 0; i < LOG_LEN; i++) log_mem[i] = '0;
    cur_pos = CURSOR_RESET;
    log_wr  = 0;
  endfunction

  function automatic void emit_rsp(logic [CHAR_W-1:0] sb, logic sv,
                                   logic [WORD_W-1:0] rd, logic lst);
    out_rsp_t r;
    r.serial_byte     = sb;
    r.serial_valid    = sv;
    r.read_data       = rd;
    r.cursor_position = CIDX_W'(cur_pos);
    r.log_position    = LIDX_W'(log_wr);
    r.last            = lst;
    console_rsp_due.push_back(r);
  endfunction

  // Move every row up one, blank the bottom row, cursor back one row
  function automatic void scroll_screen();
    for (int i = COLS; i < CELLS; i++) scr_mem[i - COLS] = scr_mem[i];
    for (int i = CELLS - COLS; i < CELLS; i++) scr_mem[i] = BLANK_WORD;
    cur_pos = cur_pos - COLS;
  endfunction

  function automatic void console_step(in_req_t r);
    logic [WORD_W-1:0] word;
    case (r.action)
      ACT_PUT: begin
        if (r.character == CH_NUL) begin
          emit_rsp('0, 1'b0, '0, 1'b1);
        end else begin
          log_mem[log_wr] = r.character;
          log_wr = (log_wr + 1) % LOG_LEN;
          if (cur_pos >= CELLS) cur_pos = 0;
          if (r.character == CH_LF) begin
            cur_pos = cur_pos - (cur_pos % COLS) + COLS;
          end else begin
            scr_mem[cur_pos] = BLANK_WORD | {8'h00, r.character};
            cur_pos++;
          end
          if (cur_pos >= CELLS) scroll_screen();
          // Newline echoes LF then an added CR
          if (r.character == CH_LF) begin
            emit_rsp(CH_LF, 1'b1, '0, 1'b0);
            emit_rsp(CH_CR, 1'b1, '0, 1'b1);
          end else begin
            emit_rsp(r.character, 1'b1, '0, 1'b1);
          end
        end
      end
      ACT_RD_CELL: begin
        word = (r.cell_index < CELLS) ? scr_mem[r.cell_index] : '0;
        emit_rsp('0, 1'b0, word, 1'b1);
      end
      ACT_RD_LOG: begin
        word = (r.log_index < LOG_LEN) ? {8'h00, log_mem[r.log_index]} : '0;
        emit_rsp('0, 1'b0, word, 1'b1);
      end
      default: begin
        emit_rsp('0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  int unsigned fail_count = 0;

  function automatic void check_rsp(out_rsp_t got);
    out_rsp_t want;
    if (console_rsp_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("error: unexpected result sb=%h sv=%b rd=%h cur=%0d log=%0d last=%b",
                 got.serial_byte, got.serial_valid, got.read_data,
                 got.cursor_position, got.log_position, got.last);
      return;
    end
    want = console_rsp_due.pop_front();
    if (got.serial_byte !== want.serial_byte || got.serial_valid !== want.serial_valid ||
        got.read_data !== want.read_data || got.cursor_position !== want.cursor_position ||
        got.log_position !== want.log_position || got.last !== want.last) begin
      fail_count++;
      // Field order: serial byte, serial valid, read data, cursor, log pointer, last
      if (fail_count <= REPORT_MAX)
        $display("error: mismatch exp %h %b %h %0d %0d %b got %h %b %h %0d %0d %b",
                 want.serial_byte, want.serial_valid, want.read_data,
                 want.cursor_position, want.log_position, want.last,
                 got.serial_byte, got.serial_valid, got.read_data,
                 got.cursor_position, got.log_position, got.last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request plan
  // ---------------------------------------------------------------------------
  in_req_t     req_plan[$];
  int unsigned planned_log_puts = 0;

  function automatic void add_req(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                  logic [CIDX_W-1:0] cidx, logic [LIDX_W-1:0] lidx);
    in_req_t r;
    r.action     = act;
    r.character  = ch;
    r.cell_index = cidx;
    r.log_index  = lidx;
    req_plan.push_back(r);
  endfunction

  // Put with random content in the unused fields
  function automatic void add_put(logic [CHAR_W-1:0] ch);
    if (ch != CH_NUL) planned_log_puts++;
    add_req(ACT_PUT, ch, CIDX_W'($urandom), LIDX_W'($urandom));
  endfunction

  // Mostly printable text, some NULs and arbitrary codes
  function automatic logic [CHAR_W-1:0] text_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return CH_NUL;
    if (pick < 12) return CHAR_W'($urandom_range(1, 255));
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  function automatic void add_line(int unsigned len);
    for (int unsigned i = 0; i < len; i++) add_put(text_char());
    add_put(CH_LF);
  endfunction

  function automatic void add_cell_read();
    logic [CIDX_W-1:0] idx;
    idx = ($urandom_range(0, 9) == 0) ? CIDX_W'($urandom) :
                                        CIDX_W'($urandom_range(0, CELLS - 1));
    add_req(ACT_RD_CELL, CHAR_W'($urandom), idx, LIDX_W'($urandom));
  endfunction

  // Half the log reads land just behind the write pointer
  function automatic void add_log_read();
    logic [LIDX_W-1:0] idx;
    if ($urandom_range(0, 1) == 0)
      idx = LIDX_W'(planned_log_puts - $urandom_range(1, 64));
    else
      idx = LIDX_W'($urandom);
    add_req(ACT_RD_LOG, CHAR_W'($urandom), CIDX_W'($urandom), idx);
  endfunction

  function automatic void build_plan();
    int unsigned start;
    int unsigned pick;
    // Directed: empty screen, range limits, every action, special characters
    add_req(ACT_RD_CELL, '0, '0, '0);
    add_req(ACT_RD_CELL, '0, 11'(CELLS - 1), '0);
    add_req(ACT_RD_CELL, '0, 11'(CELLS), '0);
    add_req(ACT_RD_CELL, '1, '1, '1);
    add_req(ACT_RD_LOG, '0, '0, '0);
    add_req(ACT_RD_LOG, '1, '1, '1);
    add_req(ACT_NONE, '1, '1, '1);
    add_req(ACT_PUT, CH_NUL, '1, '1);
    add_put(8'h41);
    add_put(8'hFF);
    add_put(8'h01);
    add_put(8'h80);
    add_put(CH_CR);
    add_put(CH_LF);
    add_put(8'h7F);
    for (int i = 0; i < 5; i++) add_req(ACT_RD_CELL, '0, 11'(CURSOR_RESET + i), '0);
    add_req(ACT_RD_CELL, '0, 11'(CURSOR_RESET + COLS), '0);
    add_req(ACT_RD_LOG, '0, '0, 12'd0);
    add_req(ACT_RD_LOG, '0, '0, 12'd1);
    add_req(ACT_RD_LOG, '0, '0, 12'd5);
    add_req(ACT_RD_CELL, '1, 11'(CURSOR_RESET + 1), '1);

    // Short lines: the cursor passes the bottom row and the screen scrolls
    while (planned_log_puts < TEXT_PUTS) begin
      add_line($urandom_range(0, 40));
      if ($urandom_range(0, 3) == 0) add_log_read();
      if ($urandom_range(0, 5) == 0) add_cell_read();
    end

    // Mixed traffic
    start = req_plan.size();
    while (req_plan.size() - start < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_line($urandom_range(0, 24));
      end else if (pick < 45) begin
        add_line($urandom_range(60, 100));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 8)) add_cell_read();
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 8)) add_log_read();
      end else if (pick < 97) begin
        add_req(ACT_NONE, CHAR_W'($urandom), CIDX_W'($urandom), LIDX_W'($urandom));
      end else begin
        add_put(CHAR_W'($urandom));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  in_req_t     cur_req   = '0;
  bit          driving   = 1'b0;
  bit          req_done  = 1'b0;
  bit          in_calm   = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned reqs_taken = 0;
  int unsigned reqs_total = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_done) begin
        req_done = 1'b0;
        driving  = 1'b0;
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        gap_left = in_calm ? 0 : $urandom_range(0, 16);
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_plan.size() > 0) begin
          cur_req = req_plan.pop_front();
          driving = 1'b1;
        end
      end
    end
    in_valid <= driving;
    in_data  <= cur_req;
  end

  // ---------------------------------------------------------------------------
  // Result stall and sampling of both channels
  // ---------------------------------------------------------------------------
  bit          out_calm    = 1'b0;
  int unsigned rsp_wait    = 0;
  int unsigned idle_cycles = 0;

  always @(negedge clk) begin
    if (rsp_wait > 0) begin
      out_stall <= 1'b1;
      rsp_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : sample_channels
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      // Predict first so a request and its result never race
      if (in_valid && !in_stall) begin
        console_step(in_data);
        reqs_taken++;
        req_done = 1'b1;
        moved    = 1'b1;
      end
      if (out_valid && !out_stall) begin
        check_rsp(out_data);
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        rsp_wait = out_calm ? 0 : $urandom_range(0, 16);
        moved    = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, run the plan, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    clear_console();
    build_plan();
    reqs_total = req_plan.size();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    while (reqs_taken < reqs_total || console_rsp_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && console_rsp_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
